/* src/fllseq_pkg.sv */
// Shared types, codes and constants of the feed, load and launch sequencer.
package fllseq_pkg;

    // Kind of control-loop tick carried by an input item
    typedef enum logic [1:0] {
        FUNC_TELEOP_TICK = 2'd0,
        FUNC_AUTO_TICK   = 2'd1,
        FUNC_AUTO_INIT   = 2'd2,
        FUNC_TELEOP_INIT = 2'd3
    } func_t;

    // Configuration register indexes
    localparam logic [2:0] CFG_FEED_TICKS        = 3'd0;
    localparam logic [2:0] CFG_LOAD_TICKS_TELEOP = 3'd1;
    localparam logic [2:0] CFG_LOAD_TICKS_AUTO   = 3'd2;
    localparam logic [2:0] CFG_PAUSE_TICKS       = 3'd3;
    localparam logic [2:0] CFG_FRISBEE_LIMIT     = 3'd4;
    localparam logic [2:0] CFG_SPIN_UP_TICKS     = 3'd5;
    localparam logic [2:0] CFG_FEED_LEVEL        = 3'd6;
    localparam logic [2:0] CFG_LOAD_LEVEL        = 3'd7;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Q1.15 command constants
    localparam logic [14:0]        LAUNCH_AUTO = 15'd26214;
    localparam logic signed [15:0] ELEV_UP     = 16'sd32767;
    localparam logic signed [15:0] ELEV_DOWN   = -16'sd32767;
    localparam logic signed [15:0] TRIM_FWD    = 16'sd4915;
    localparam logic signed [15:0] TRIM_REV    = -16'sd3277;

    // Widths of the streaming payloads
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 72;

    // Configuration register file contents
    typedef struct packed {
        logic [7:0]  feed_ticks;
        logic [9:0]  load_ticks_teleop;
        logic [9:0]  load_ticks_auto;
        logic [7:0]  pause_ticks;
        logic [3:0]  frisbee_limit;
        logic [15:0] spin_up_ticks;
        logic [14:0] feed_level;
        logic [14:0] load_level;
    } cfg_t;

    // One input item
    typedef struct packed {
        func_t              func;
        logic               feed_request;
        logic               load_request;
        logic               limit_open;
        logic               elevate_up;
        logic               elevate_down;
        logic               trim_forward;
        logic               trim_reverse;
        logic signed [15:0] z_axis;
    } item_t;

    // Sequencer state carried from tick to tick
    typedef struct packed {
        logic               feeding;
        logic               loading;
        logic               breech;
        logic [7:0]         feed_cnt;
        logic [15:0]        load_cnt;
        logic [15:0]        auto_cnt;
        logic [3:0]         frisbee_cnt;
        logic signed [15:0] feed_cmd;
        logic signed [15:0] load_cmd;
        logic [14:0]        launch_cmd;
        logic signed [15:0] elevator_cmd;
    } seq_state_t;

endpackage

/* src/fllseq_cfg.sv */
// Configuration register file of the sequencer.
module fllseq_cfg (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [fllseq_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [fllseq_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output fllseq_pkg::cfg_t                     cfg
);

    fllseq_pkg::cfg_t cfg_reg;

    // Registers load their reset values and take writes by index.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.feed_ticks        <= 8'd50;
            cfg_reg.load_ticks_teleop <= 10'd58;
            cfg_reg.load_ticks_auto   <= 10'd60;
            cfg_reg.pause_ticks       <= 8'd2;
            cfg_reg.frisbee_limit     <= 4'd3;
            cfg_reg.spin_up_ticks     <= 16'd100;
            cfg_reg.feed_level        <= 15'd16384;
            cfg_reg.load_level        <= 15'd6554;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                fllseq_pkg::CFG_FEED_TICKS:        cfg_reg.feed_ticks <= cfg_wdata[7:0];
                fllseq_pkg::CFG_LOAD_TICKS_TELEOP: cfg_reg.load_ticks_teleop <= cfg_wdata[9:0];
                fllseq_pkg::CFG_LOAD_TICKS_AUTO:   cfg_reg.load_ticks_auto <= cfg_wdata[9:0];
                fllseq_pkg::CFG_PAUSE_TICKS:       cfg_reg.pause_ticks <= cfg_wdata[7:0];
                fllseq_pkg::CFG_FRISBEE_LIMIT:     cfg_reg.frisbee_limit <= cfg_wdata[3:0];
                fllseq_pkg::CFG_SPIN_UP_TICKS:     cfg_reg.spin_up_ticks <= cfg_wdata[15:0];
                fllseq_pkg::CFG_FEED_LEVEL:        cfg_reg.feed_level <= cfg_wdata[14:0];
                fllseq_pkg::CFG_LOAD_LEVEL:        cfg_reg.load_level <= cfg_wdata[14:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/fllseq_step.sv */
// Next-state logic of the sequencer for one control-loop tick.
module fllseq_step (
    input  fllseq_pkg::seq_state_t cur,
    input  fllseq_pkg::item_t      item,
    input  fllseq_pkg::cfg_t       cfg,
    output fllseq_pkg::seq_state_t nxt
);

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic [7:0] sat_inc8(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    function automatic logic [3:0] sat_inc4(input logic [3:0] v);
        return (v == 4'hF) ? v : v + 4'd1;
    endfunction

    // True when the loader phase takes its done branch.
    function automatic logic loader_done(input logic [15:0] cnt, input logic [9:0] fwd,
                                         input logic [7:0] pause, input logic open);
        logic [10:0] end_cnt;
        end_cnt = {1'b0, fwd} + {3'b000, pause};
        return (cnt > {6'd0, fwd}) && (cnt > {5'd0, end_cnt}) && !open;
    endfunction

    // Loader phase: forward, pause, retract until the switch closes, done.
    function automatic fllseq_pkg::seq_state_t loader_phase(
        input fllseq_pkg::seq_state_t s,
        input logic [9:0]             fwd,
        input logic [7:0]             pause,
        input logic [14:0]            lvl,
        input logic                   open,
        input logic                   count_retract
    );
        fllseq_pkg::seq_state_t r;
        logic [10:0]            end_cnt;
        r = s;
        end_cnt = {1'b0, fwd} + {3'b000, pause};
        if (s.load_cnt <= {6'd0, fwd}) begin
            r.load_cnt = sat_inc16(s.load_cnt);
            r.load_cmd = $signed({1'b0, lvl});
        end else if (s.load_cnt <= {5'd0, end_cnt}) begin
            r.load_cnt = sat_inc16(s.load_cnt);
            r.load_cmd = '0;
        end else if (open) begin
            if (count_retract) begin
                r.load_cnt = sat_inc16(s.load_cnt);
            end
            r.load_cmd = -$signed({1'b0, lvl});
        end else begin
            r.loading  = 1'b0;
            r.load_cnt = '0;
            r.load_cmd = '0;
        end
        return r;
    endfunction

    fllseq_pkg::seq_state_t s;
    logic                   done;
    logic [16:0]            launch_diff;
    logic                   below_limit;

    // One tick of the sequencer, chosen by the item's kind.
    always_comb begin
        s           = cur;
        done        = 1'b0;
        launch_diff = 17'h08000 - {item.z_axis[15], item.z_axis};
        below_limit = 1'b0;

        unique case (item.func)
            fllseq_pkg::FUNC_TELEOP_TICK: begin
                // Elevator from the two buttons
                if (item.elevate_up) begin
                    s.elevator_cmd = fllseq_pkg::ELEV_UP;
                end else if (item.elevate_down) begin
                    s.elevator_cmd = fllseq_pkg::ELEV_DOWN;
                end else begin
                    s.elevator_cmd = '0;
                end

                // Feed phase
                if ((item.feed_request || s.feeding) && !s.loading
                        && s.feed_cnt <= cfg.feed_ticks) begin
                    s.feeding  = 1'b1;
                    s.feed_cnt = sat_inc8(s.feed_cnt);
                    s.feed_cmd = $signed({1'b0, cfg.feed_level});
                end else begin
                    s.feeding  = 1'b0;
                    s.feed_cnt = '0;
                    s.feed_cmd = '0;
                end

                // Load phase, after the feed decision
                if ((item.load_request || s.loading) && !s.feeding
                        && s.load_cnt <= {6'd0, cfg.load_ticks_teleop}) begin
                    s.loading  = 1'b1;
                    s.load_cnt = sat_inc16(s.load_cnt);
                    s.load_cmd = $signed({1'b0, cfg.load_level});
                end else if (s.loading && !s.feeding) begin
                    s = loader_phase(s, cfg.load_ticks_teleop, cfg.pause_ticks,
                                     cfg.load_level, item.limit_open, 1'b1);
                end else begin
                    s.loading  = 1'b0;
                    s.load_cnt = '0;
                    s.load_cmd = '0;
                end

                // Launcher from the Z wheel: (1 - z) / 2, saturated
                s.launch_cmd = launch_diff[16] ? 15'h7FFF : launch_diff[15:1];

                // Feed trim while the sequence is idle
                if (item.trim_forward && !s.feeding && !s.loading) begin
                    s.feed_cmd = fllseq_pkg::TRIM_FWD;
                end else if (item.trim_reverse && !s.feeding && !s.loading) begin
                    s.feed_cmd = fllseq_pkg::TRIM_REV;
                end
            end

            fllseq_pkg::FUNC_AUTO_TICK: begin
                s.auto_cnt  = sat_inc16(s.auto_cnt);
                below_limit = s.frisbee_cnt < cfg.frisbee_limit;
                if (below_limit) begin
                    s.launch_cmd = fllseq_pkg::LAUNCH_AUTO;
                end

                if (s.breech && s.auto_cnt >= cfg.spin_up_ticks) begin
                    // Clear the breech once the launcher is up to speed
                    if (!s.loading) begin
                        s.load_cnt = '0;
                        s.load_cmd = '0;
                        s.breech   = 1'b0;
                    end else begin
                        done = loader_done(s.load_cnt, cfg.load_ticks_auto,
                                           cfg.pause_ticks, item.limit_open);
                        s = loader_phase(s, cfg.load_ticks_auto, cfg.pause_ticks,
                                         cfg.load_level, item.limit_open, 1'b0);
                        if (done) begin
                            s.breech = 1'b0;
                        end
                    end
                end else if (below_limit && !s.breech) begin
                    // Feed, then load, one frisbee per feed/load sequence
                    if (s.feeding && !item.limit_open && s.feed_cnt <= cfg.feed_ticks) begin
                        s.feed_cnt = sat_inc8(s.feed_cnt);
                        s.feed_cmd = $signed({1'b0, cfg.feed_level});
                    end else if (s.feeding && !item.limit_open) begin
                        s.feeding  = 1'b0;
                        s.loading  = 1'b1;
                        s.feed_cnt = '0;
                        s.feed_cmd = '0;
                    end else begin
                        if (s.loading && !s.feeding) begin
                            done = loader_done(s.load_cnt, cfg.load_ticks_auto,
                                               cfg.pause_ticks, item.limit_open);
                            s = loader_phase(s, cfg.load_ticks_auto, cfg.pause_ticks,
                                             cfg.load_level, item.limit_open, 1'b0);
                        end else begin
                            s.loading  = 1'b0;
                            s.load_cnt = '0;
                            s.load_cmd = '0;
                            done       = 1'b1;
                        end
                        if (done) begin
                            s.frisbee_cnt = sat_inc4(s.frisbee_cnt);
                            s.feeding     = 1'b1;
                        end
                    end
                end else if (!below_limit) begin
                    s.launch_cmd = '0;
                end
            end

            fllseq_pkg::FUNC_AUTO_INIT: begin
                s.auto_cnt    = '0;
                s.feeding     = 1'b1;
                s.feed_cnt    = '0;
                s.loading     = 1'b1;
                s.load_cnt    = '0;
                s.frisbee_cnt = '0;
                s.breech      = 1'b1;
            end

            fllseq_pkg::FUNC_TELEOP_INIT: begin
                s.feeding  = 1'b0;
                s.feed_cnt = '0;
                s.loading  = 1'b0;
                s.load_cnt = '0;
            end

            default: begin
            end
        endcase

        nxt = s;
    end

endmodule

/* src/feed_load_launch_sequencer_core.sv */
// Top level of the feed, load and launch sequencer with its stream ports.
// An accepted item is held in the input register, and its result is then
// written to the result register. Throughput: one item per cycle unless
// m_tready stalls; combinational tick logic between them updates the state.
// Reset: synchronous active-low aresetn clears all flags, counters and held
// commands and loads the configuration registers with their default values.
module feed_load_launch_sequencer_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [0] feed_request, [1] load_request, [2] limit_open, [3] elevate_up,
    // [4] elevate_down, [5] trim_forward, [6] trim_reverse, [22:7] z_axis
    input  logic [fllseq_pkg::S_TDATA_W-1:0]    s_tdata,
    // [1:0] func
    input  logic [1:0]                          s_tuser,
    // Result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [15:0] feed_cmd, [31:16] load_cmd, [46:32] launch_cmd,
    // [62:47] elevator_cmd, [66:63] launched_count, [67] is_feeding,
    // [68] is_loading
    output logic [fllseq_pkg::M_TDATA_W-1:0]    m_tdata,
    // Configuration writes
    input  logic                                cfg_wr_en,
    input  logic [fllseq_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [fllseq_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    fllseq_pkg::cfg_t       cfg;
    fllseq_pkg::item_t      item_reg;
    fllseq_pkg::seq_state_t state_reg;
    fllseq_pkg::seq_state_t state_next;
    logic                   in_valid_reg;
    logic                   out_valid_reg;
    logic [fllseq_pkg::M_TDATA_W-1:0] out_data_reg;
    logic [fllseq_pkg::M_TDATA_W-1:0] out_data_next;
    logic                   advance;

    fllseq_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    fllseq_step u_step (
        .cur  (state_reg),
        .item (item_reg),
        .cfg  (cfg),
        .nxt  (state_next)
    );

    // The result register moves when it is empty or being taken.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.func         <= fllseq_pkg::func_t'(s_tuser[1:0]);
            item_reg.feed_request <= s_tdata[0];
            item_reg.load_request <= s_tdata[1];
            item_reg.limit_open   <= s_tdata[2];
            item_reg.elevate_up   <= s_tdata[3];
            item_reg.elevate_down <= s_tdata[4];
            item_reg.trim_forward <= s_tdata[5];
            item_reg.trim_reverse <= s_tdata[6];
            item_reg.z_axis       <= $signed(s_tdata[22:7]);
        end
    end

    // Sequencer state advances once per processed item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance && in_valid_reg) begin
            state_reg <= state_next;
        end
    end

    // Result packing from the state after the tick
    assign out_data_next = {3'b000,
                            state_next.loading,
                            state_next.feeding,
                            state_next.frisbee_cnt,
                            state_next.elevator_cmd,
                            state_next.launch_cmd,
                            state_next.load_cmd,
                            state_next.feed_cmd};

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* verif/feed_load_launch_sequencer_core_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the feed, load and launch sequencer core.
module feed_load_launch_sequencer_core_tb;

    localparam int STALL_LIMIT    = 2000;
    localparam int TAIL_CYCLES    = 8;
    localparam int FEED_COUNT_MAX = 255;
    localparam int LOAD_COUNT_MAX = 65535;
    localparam int FRISBEE_MAX    = 15;

    typedef enum {SET_ZERO, SET_MAX, SET_QUICK, SET_WIDE} setting_kind_t;

    // One result item, split into its fields
    typedef struct packed {
        logic [15:0] feed_cmd;
        logic [15:0] load_cmd;
        logic [14:0] launch_cmd;
        logic [15:0] elevator_cmd;
        logic [3:0]  launched_count;
        logic        is_feeding;
        logic        is_loading;
    } tick_result_t;

    logic                               aclk;
    logic                               aresetn   = 1'b0;
    logic                               s_tvalid  = 1'b0;
    logic                               s_tready;
    logic [fllseq_pkg::S_TDATA_W-1:0]   s_tdata   = '0;
    logic [1:0]                         s_tuser   = '0;
    logic                               m_tvalid;
    logic                               m_tready  = 1'b0;
    logic [fllseq_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                               cfg_wr_en = 1'b0;
    logic [fllseq_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [fllseq_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int mismatch_count = 0;
    int stall_cycles   = 0;

    // Expected results, oldest first
    tick_result_t pending_results[$];

    // Mirror of the sequencer settings and state
    fllseq_pkg::cfg_t shadow_cfg = '{feed_ticks: 8'd50, load_ticks_teleop: 10'd58,
                                     load_ticks_auto: 10'd60, pause_ticks: 8'd2,
                                     frisbee_limit: 4'd3, spin_up_ticks: 16'd100,
                                     feed_level: 15'd16384, load_level: 15'd6554};
    bit run_feeding, run_loading, breech_pending;
    int feed_count, load_count, auto_count, frisbee_total;
    int cmd_feed, cmd_load, cmd_launch, cmd_elev;

    feed_load_launch_sequencer_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int sat_up(int v, int top);
        return (v < top) ? v + 1 : top;
    endfunction

    // Loader forward, pause and retract phases; returns 1 once the switch
    // closes during the retract.
    function automatic bit loader_step(int fwd, bit open, bit count_retract);
        if (load_count <= fwd) begin
            load_count = sat_up(load_count, LOAD_COUNT_MAX);
            cmd_load   = shadow_cfg.load_level;
            return 1'b0;
        end
        if (load_count <= fwd + shadow_cfg.pause_ticks) begin
            load_count = sat_up(load_count, LOAD_COUNT_MAX);
            cmd_load   = 0;
            return 1'b0;
        end
        if (open) begin
            if (count_retract)
                load_count = sat_up(load_count, LOAD_COUNT_MAX);
            cmd_load = -int'(shadow_cfg.load_level);
            return 1'b0;
        end
        run_loading = 1'b0;
        load_count  = 0;
        cmd_load    = 0;
        return 1'b1;
    endfunction

    // Autonomous tick: spin-up wait, breech clearing, then feed/load cycles.
    function automatic void autonomous_tick(bit open);
        bit done;
        auto_count = sat_up(auto_count, LOAD_COUNT_MAX);
        if (frisbee_total < shadow_cfg.frisbee_limit)
            cmd_launch = fllseq_pkg::LAUNCH_AUTO;

        if (breech_pending && auto_count >= shadow_cfg.spin_up_ticks) begin
            if (!run_loading) begin
                load_count     = 0;
                cmd_load       = 0;
                breech_pending = 1'b0;
            end else if (loader_step(shadow_cfg.load_ticks_auto, open, 1'b0)) begin
                breech_pending = 1'b0;
            end
        end else if (frisbee_total < shadow_cfg.frisbee_limit && !breech_pending) begin
            if (run_feeding && !open && feed_count <= shadow_cfg.feed_ticks) begin
                feed_count = sat_up(feed_count, FEED_COUNT_MAX);
                cmd_feed   = shadow_cfg.feed_level;
            end else if (run_feeding && !open) begin
                run_feeding = 1'b0;
                run_loading = 1'b1;
                feed_count  = 0;
                cmd_feed    = 0;
            end else begin
                if (run_loading && !run_feeding) begin
                    done = loader_step(shadow_cfg.load_ticks_auto, open, 1'b0);
                end else begin
                    run_loading = 1'b0;
                    load_count  = 0;
                    cmd_load    = 0;
                    done        = 1'b1;
                end
                if (done) begin
                    frisbee_total = sat_up(frisbee_total, FRISBEE_MAX);
                    run_feeding   = 1'b1;
                end
            end
        end else if (frisbee_total >= shadow_cfg.frisbee_limit) begin
            cmd_launch = 0;
        end
    endfunction

    // Teleop tick: elevator, feed, loader, launcher from the wheel, feed trim.
    function automatic void teleop_tick(fllseq_pkg::item_t it);
        int zs;
        zs = $signed(it.z_axis);
        if (it.elevate_up)
            cmd_elev = fllseq_pkg::ELEV_UP;
        else if (it.elevate_down)
            cmd_elev = fllseq_pkg::ELEV_DOWN;
        else
            cmd_elev = 0;

        if ((it.feed_request || run_feeding) && !run_loading
                && feed_count <= shadow_cfg.feed_ticks) begin
            run_feeding = 1'b1;
            feed_count  = sat_up(feed_count, FEED_COUNT_MAX);
            cmd_feed    = shadow_cfg.feed_level;
        end else begin
            run_feeding = 1'b0;
            feed_count  = 0;
            cmd_feed    = 0;
        end

        if ((it.load_request || run_loading) && !run_feeding
                && load_count <= shadow_cfg.load_ticks_teleop) begin
            run_loading = 1'b1;
            load_count  = sat_up(load_count, LOAD_COUNT_MAX);
            cmd_load    = shadow_cfg.load_level;
        end else if (run_loading && !run_feeding) begin
            void'(loader_step(shadow_cfg.load_ticks_teleop, it.limit_open, 1'b1));
        end else begin
            run_loading = 1'b0;
            load_count  = 0;
            cmd_load    = 0;
        end

        // Launcher follows (1 - z) / 2; only the most negative wheel position saturates
        cmd_launch = (32768 - zs) / 2;
        if (cmd_launch > 32767)
            cmd_launch = 32767;

        if (it.trim_forward && !run_feeding && !run_loading)
            cmd_feed = fllseq_pkg::TRIM_FWD;
        else if (it.trim_reverse && !run_feeding && !run_loading)
            cmd_feed = fllseq_pkg::TRIM_REV;
    endfunction

    // Advance the mirror by one accepted item and queue the result it causes.
    function automatic void predict_tick(fllseq_pkg::item_t it);
        tick_result_t r;
        case (it.func)
            fllseq_pkg::FUNC_TELEOP_TICK: teleop_tick(it);
            fllseq_pkg::FUNC_AUTO_TICK:   autonomous_tick(it.limit_open);
            fllseq_pkg::FUNC_AUTO_INIT: begin
                auto_count     = 0;
                run_feeding    = 1'b1;
                feed_count     = 0;
                run_loading    = 1'b1;
                load_count     = 0;
                frisbee_total  = 0;
                breech_pending = 1'b1;
            end
            fllseq_pkg::FUNC_TELEOP_INIT: begin
                run_feeding = 1'b0;
                feed_count  = 0;
                run_loading = 1'b0;
                load_count  = 0;
            end
        endcase
        r.feed_cmd       = 16'(cmd_feed);
        r.load_cmd       = 16'(cmd_load);
        r.launch_cmd     = 15'(cmd_launch);
        r.elevator_cmd   = 16'(cmd_elev);
        r.launched_count = 4'(frisbee_total);
        r.is_feeding     = run_feeding;
        r.is_loading     = run_loading;
        pending_results.push_back(r);
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            mismatch_count++;
            $error("%s: expected %h, got %h", name, want, got);
        end
    endfunction

    // Random buttons and wheel, with the wheel extremes now and then.
    function automatic fllseq_pkg::item_t random_item(fllseq_pkg::func_t f);
        fllseq_pkg::item_t it;
        it      = fllseq_pkg::item_t'($urandom);
        it.func = f;
        case ($urandom_range(0, 9))
            0:       it.z_axis = 16'sh8000;
            1:       it.z_axis = 16'sh7FFF;
            default: ;
        endcase
        return it;
    endfunction

    // Limit switch: held open for a while during a retract, mostly closed otherwise.
    function automatic bit switch_reading(int fwd);
        if (run_loading && load_count > fwd + shadow_cfg.pause_ticks)
            return $urandom_range(0, 3) != 0;
        return $urandom_range(0, 9) == 0;
    endfunction

    function automatic fllseq_pkg::cfg_t make_setting(setting_kind_t kind);
        fllseq_pkg::cfg_t c;
        c = '0;
        case (kind)
            SET_ZERO: ;
            SET_MAX: begin
                c = '{feed_ticks: 8'd254, load_ticks_teleop: 10'h3FF, load_ticks_auto: 10'h3FF,
                      pause_ticks: 8'hFF, frisbee_limit: 4'hF, spin_up_ticks: 16'hFFFF,
                      feed_level: 15'h7FFF, load_level: 15'h7FFF};
            end
            SET_QUICK: begin
                c.feed_ticks        = 8'($urandom_range(0, 4));
                c.load_ticks_teleop = 10'($urandom_range(0, 6));
                c.load_ticks_auto   = 10'($urandom_range(0, 6));
                c.pause_ticks       = 8'($urandom_range(0, 3));
                c.frisbee_limit     = 4'($urandom_range(0, 15));
                c.spin_up_ticks     = 16'($urandom_range(0, 6));
                c.feed_level        = 15'($urandom_range(0, 32767));
                c.load_level        = 15'($urandom_range(0, 32767));
            end
            SET_WIDE: begin
                c.feed_ticks        = 8'($urandom_range(0, 254));
                c.load_ticks_teleop = 10'($urandom_range(0, 1023));
                c.load_ticks_auto   = 10'($urandom_range(0, 1023));
                c.pause_ticks       = 8'($urandom_range(0, 255));
                c.frisbee_limit     = 4'($urandom_range(0, 15));
                c.spin_up_ticks     = 16'($urandom_range(0, 65535));
                c.feed_level        = 15'($urandom_range(0, 32767));
                c.load_level        = 15'($urandom_range(0, 32767));
            end
        endcase
        return c;
    endfunction

    // Offer one item after a random gap and wait until it is taken.
    task automatic send_tick(input fllseq_pkg::item_t it);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.func;
        s_tdata  <= {1'b0, it.z_axis, it.trim_reverse, it.trim_forward, it.elevate_down,
                     it.elevate_up, it.limit_open, it.load_request, it.feed_request};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_tick(it);
    endtask

    // Stop sending and let every expected result come out.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // Write all eight registers back to back once the block is idle.
    task automatic apply_setting(input fllseq_pkg::cfg_t c);
        logic [fllseq_pkg::CFG_INDEX_W-1:0] reg_ids [8];
        logic [fllseq_pkg::CFG_DATA_W-1:0]  reg_vals [8];
        reg_ids  = '{fllseq_pkg::CFG_FEED_TICKS, fllseq_pkg::CFG_LOAD_TICKS_TELEOP,
                     fllseq_pkg::CFG_LOAD_TICKS_AUTO, fllseq_pkg::CFG_PAUSE_TICKS,
                     fllseq_pkg::CFG_FRISBEE_LIMIT, fllseq_pkg::CFG_SPIN_UP_TICKS,
                     fllseq_pkg::CFG_FEED_LEVEL, fllseq_pkg::CFG_LOAD_LEVEL};
        reg_vals = '{16'(c.feed_ticks), 16'(c.load_ticks_teleop), 16'(c.load_ticks_auto),
                     16'(c.pause_ticks), 16'(c.frisbee_limit), c.spin_up_ticks,
                     16'(c.feed_level), 16'(c.load_level)};
        drain_results();
        for (int i = 0; i < 8; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= reg_ids[i];
            cfg_wdata <= reg_vals[i];
            @(posedge aclk);
        end
        cfg_wr_en  <= 1'b0;
        shadow_cfg  = c;
    endtask

    // Teleop basics at the reset settings: wheel extremes, elevator, trims, requests.
    task automatic test_teleop_basics();
        fllseq_pkg::item_t it;
        it      = '0;
        it.func = fllseq_pkg::FUNC_TELEOP_INIT;
        send_tick(it);
        it.func       = fllseq_pkg::FUNC_TELEOP_TICK;
        it.z_axis     = 16'sh8000;
        it.elevate_up = 1'b1;
        send_tick(it);
        it.z_axis       = 16'sh7FFF;
        it.elevate_up   = 1'b0;
        it.elevate_down = 1'b1;
        send_tick(it);
        // Both elevator buttons: up wins.
        it.z_axis       = '0;
        it.elevate_up   = 1'b1;
        it.trim_forward = 1'b1;
        send_tick(it);
        it.elevate_up   = 1'b0;
        it.elevate_down = 1'b0;
        it.trim_forward = 1'b0;
        it.trim_reverse = 1'b1;
        send_tick(it);
        // Both trims: forward wins.
        it.trim_forward = 1'b1;
        send_tick(it);
        // Feeding masks the trim, and a load request is ignored while feeding.
        it.feed_request = 1'b1;
        send_tick(it);
        it.feed_request = 1'b0;
        it.load_request = 1'b1;
        send_tick(it);
        it.func = fllseq_pkg::FUNC_TELEOP_INIT;
        send_tick(it);
        it.func         = fllseq_pkg::FUNC_TELEOP_TICK;
        it.trim_forward = 1'b0;
        send_tick(it);
    endtask

    // One short scripted autonomous run: spin-up, breech clearing, an open switch
    // while feeding, a full feed/load cycle, then the frisbee limit.
    task automatic test_autonomous_basics();
        fllseq_pkg::item_t it;
        bit [15:0]         open_pattern;
        open_pattern = 16'b0010_0000_0101_0000;
        apply_setting('{feed_ticks: 8'd1, load_ticks_teleop: 10'd1, load_ticks_auto: 10'd1,
                        pause_ticks: 8'd1, frisbee_limit: 4'd2, spin_up_ticks: 16'd2,
                        feed_level: 15'd16384, load_level: 15'd6554});
        it      = '0;
        it.func = fllseq_pkg::FUNC_AUTO_INIT;
        send_tick(it);
        it.func = fllseq_pkg::FUNC_AUTO_TICK;
        for (int i = 0; i < 16; i++) begin
            it.limit_open = open_pattern[i];
            send_tick(it);
        end
    endtask

    // Teleop runs with sparse requests; halfway the sender waits for every result.
    task automatic test_teleop_runs(input int count);
        fllseq_pkg::item_t it;
        send_tick(random_item(fllseq_pkg::FUNC_TELEOP_INIT));
        for (int i = 0; i < count; i++) begin
            if (i == count / 2)
                drain_results();
            it = random_item(($urandom_range(0, 19) == 0) ? fllseq_pkg::FUNC_TELEOP_INIT
                                                          : fllseq_pkg::FUNC_TELEOP_TICK);
            it.feed_request = ($urandom_range(0, 9) == 0);
            it.load_request = ($urandom_range(0, 9) == 0);
            it.limit_open   = switch_reading(shadow_cfg.load_ticks_teleop);
            send_tick(it);
        end
    endtask

    // Autonomous runs from an init, with an occasional re-init or stray teleop tick.
    task automatic test_autonomous_runs(input int count);
        fllseq_pkg::item_t it;
        int                pick;
        send_tick(random_item(fllseq_pkg::FUNC_AUTO_INIT));
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 39);
            it   = random_item((pick == 0) ? fllseq_pkg::FUNC_AUTO_INIT :
                               (pick == 1) ? fllseq_pkg::FUNC_TELEOP_TICK :
                                             fllseq_pkg::FUNC_AUTO_TICK);
            it.limit_open = switch_reading(shadow_cfg.load_ticks_auto);
            send_tick(it);
        end
    endtask

    task automatic test_random_noise(input int count);
        for (int i = 0; i < count; i++)
            send_tick(random_item(fllseq_pkg::func_t'($urandom_range(0, 3))));
    endtask

    // A long retract with the switch held open, then autonomous ticks that all
    // fall inside a long spin-up.
    task automatic test_long_retract();
        fllseq_pkg::item_t it;
        apply_setting('{feed_ticks: 8'd0, load_ticks_teleop: 10'd0, load_ticks_auto: 10'd0,
                        pause_ticks: 8'd0, frisbee_limit: 4'd1, spin_up_ticks: 16'hFFFF,
                        feed_level: 15'd100, load_level: 15'd200});
        send_tick(random_item(fllseq_pkg::FUNC_TELEOP_INIT));
        for (int i = 0; i < 12; i++) begin
            it              = random_item(fllseq_pkg::FUNC_TELEOP_TICK);
            it.feed_request = 1'b0;
            it.load_request = (i == 0);
            it.limit_open   = 1'b1;
            send_tick(it);
        end
        it            = random_item(fllseq_pkg::FUNC_TELEOP_TICK);
        it.limit_open = 1'b0;
        send_tick(it);

        send_tick(random_item(fllseq_pkg::FUNC_AUTO_INIT));
        for (int i = 0; i < 10; i++) begin
            it            = random_item(fllseq_pkg::FUNC_AUTO_TICK);
            it.limit_open = 1'b0;
            send_tick(it);
        end
    endtask

    // Compare each result with the oldest expectation; stall the result side at random.
    always @(posedge aclk) begin
        tick_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $error("result item with no expectation waiting: %h", m_tdata);
            end else begin
                want = pending_results.pop_front();
                check_field("feed_cmd",       want.feed_cmd,       m_tdata[15:0]);
                check_field("load_cmd",       want.load_cmd,       m_tdata[31:16]);
                check_field("launch_cmd",     want.launch_cmd,     m_tdata[46:32]);
                check_field("elevator_cmd",   want.elevator_cmd,   m_tdata[62:47]);
                check_field("launched_count", want.launched_count, m_tdata[66:63]);
                check_field("is_feeding",     want.is_feeding,     m_tdata[67]);
                check_field("is_loading",     want.is_loading,     m_tdata[68]);
            end
        end
        m_tready <= aresetn && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watchdog on cycles in which neither side moves an item.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        send_idle_pct = 26;
        recv_idle_pct = 80;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_teleop_basics();
        test_autonomous_basics();

        // Random part under three idling patterns, settings changed between runs.
        for (int m = 0; m < 3; m++) begin
            send_idle_pct = (m == 0) ? 26 : (m == 1) ? 80 : 0;
            recv_idle_pct = (m == 0) ? 80 : (m == 1) ? 26 : 0;
            apply_setting(make_setting(SET_QUICK));
            test_teleop_runs(45);
            apply_setting(make_setting(SET_QUICK));
            test_autonomous_runs(50);
            apply_setting(make_setting((m == 0) ? SET_ZERO : (m == 1) ? SET_MAX : SET_WIDE));
            test_random_noise(35);
        end

        test_long_retract();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
src/fllseq_pkg.sv
src/fllseq_cfg.sv
src/fllseq_step.sv
src/feed_load_launch_sequencer_core.sv
verif/feed_load_launch_sequencer_core_tb.sv
